@@ src/two_set_membership_engine_macros.svh @@
// Assertion macros for the two-set membership engine.
// Used by the top level only; no other dependencies.
`ifndef TWO_SET_MEMBERSHIP_ENGINE_MACROS_SVH
`define TWO_SET_MEMBERSHIP_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define TSME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("property violated");
`define TSME_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("property violated");
`else
`define TSME_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSME_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/tsme_pkg.sv @@
// Package for the two-set membership engine: item types, command and status codes,
// controller states and the controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsme_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 5;

	typedef enum logic [2:0] {
		OP_ADD       = 3'd0,
		OP_REMOVE    = 3'd1,
		OP_CONTAINS  = 3'd2,
		OP_SIZE      = 3'd3,
		OP_SUBSET    = 3'd4,
		OP_EQUAL     = 3'd5,
		OP_UNION     = 3'd6,
		OP_INTERSECT = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		op_t                       cmd;
		logic                      which_set;
		logic signed [VALUE_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic                      answer;
		logic [COUNT_W-1:0]        count;
		status_t                   status;
		logic signed [VALUE_W-1:0] item_out;
		logic                      item_valid;
		logic                      last;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_status_t;

endpackage

`default_nettype wire

@@ src/tsme_ctrl.sv @@
// Controller state machine of the two-set membership engine.
// Sequences load, single-step execute, slot scan and finish; uses tsme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsme_ctrl import tsme_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  op_t        op,
	input  dp_status_t stat,
	output logic       busy,
	output ctrl_cmd_t  ctl
);

	fsm_t state_q;
	fsm_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					if (op == OP_ADD || op == OP_REMOVE || op == OP_CONTAINS || op == OP_SIZE) begin
						state_d = S_EXEC;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = S_IDLE;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				ctl.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ src/tsme_datapath.sv @@
// Datapath of the two-set membership engine: slot stores, compare bank, counts,
// scan index and the result register. Driven by tsme_ctrl; uses tsme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsme_datapath import tsme_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  request_t   request,
	input  ctrl_cmd_t  ctl,
	output dp_status_t stat,
	output result_t    result,
	output logic       strobe
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

	op_t                  op_q;
	logic                 sel_q;
	logic [VALUE_W-1:0]   key_q;
	logic [VALUE_W-1:0]   val_q [2][CAPACITY];
	logic [1:0][CAPACITY-1:0] vld_q;
	logic [CW-1:0]        cnt_q [2];
	logic [IW-1:0]        idx_q;
	logic                 phase_q;
	logic                 pend_vld_q;
	logic [VALUE_W-1:0]   pend_item_q;
	logic                 ans_q;
	result_t              out_q;
	logic                 strobe_q;

	logic                 src;
	logic                 srch_set;
	logic [VALUE_W-1:0]   srch_key;
	logic [CAPACITY-1:0]  hit;
	logic                 hit_any;
	logic [IW-1:0]        hit_idx;
	logic [CAPACITY-1:0]  sel_vld;
	logic [CAPACITY-1:0]  free_oh;
	logic [IW-1:0]        free_idx;
	logic                 full;
	logic                 cur_vld;
	logic [VALUE_W-1:0]   cur_val;
	logic                 take;
	logic                 fail;
	logic                 add_en;
	logic                 rem_en;
	logic                 res_load;
	result_t              res_d;

	assign src      = sel_q ^ phase_q;
	assign cur_vld  = vld_q[src][idx_q];
	assign cur_val  = val_q[src][idx_q];
	assign srch_set = ctl.exec ? sel_q : ~src;
	assign srch_key = ctl.exec ? key_q : cur_val;
	assign sel_vld  = vld_q[sel_q];
	assign free_oh  = ~sel_vld & (sel_vld + 1'b1);
	assign full     = &sel_vld;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			hit[j] = vld_q[srch_set][j] && (val_q[srch_set][j] == srch_key);
			if (hit[j]) begin
				hit_idx = hit_idx | IW'(j);
			end
			if (free_oh[j]) begin
				free_idx = free_idx | IW'(j);
			end
		end
		hit_any = |hit;
	end

	always_comb begin
		take = 1'b0;
		fail = 1'b0;
		case (op_q)
			OP_SUBSET, OP_EQUAL: fail = cur_vld && !hit_any;
			OP_UNION:            take = cur_vld && (!phase_q || !hit_any);
			OP_INTERSECT:        take = cur_vld && hit_any;
			default:             ;
		endcase
	end

	assign stat.scan_done = (idx_q == LastIdx) && (op_q != OP_UNION || phase_q);

	always_comb begin
		res_d       = '0;
		res_d.count = COUNT_W'(cnt_q[sel_q]);
		res_load    = 1'b0;
		add_en      = 1'b0;
		rem_en      = 1'b0;
		if (ctl.exec) begin
			res_load   = 1'b1;
			res_d.last = 1'b1;
			case (op_q)
				OP_ADD: begin
					if (hit_any) begin
						res_d.status = ST_DUP;
					end else if (full) begin
						res_d.status = ST_FULL;
					end else begin
						add_en      = 1'b1;
						res_d.count = COUNT_W'(cnt_q[sel_q] + 1'b1);
					end
				end
				OP_REMOVE: begin
					if (hit_any) begin
						rem_en      = 1'b1;
						res_d.count = COUNT_W'(cnt_q[sel_q] - 1'b1);
					end else begin
						res_d.status = ST_ABSENT;
					end
				end
				OP_CONTAINS: res_d.answer = hit_any;
				default:     ;
			endcase
		end
		if (ctl.scan && take && pend_vld_q) begin
			res_load         = 1'b1;
			res_d.item_out   = pend_item_q;
			res_d.item_valid = 1'b1;
		end
		if (ctl.finish) begin
			res_load   = 1'b1;
			res_d.last = 1'b1;
			case (op_q)
				OP_SUBSET: res_d.answer = ans_q;
				OP_EQUAL:  res_d.answer = ans_q && (cnt_q[0] == cnt_q[1]);
				default: begin
					res_d.item_out   = pend_vld_q ? pend_item_q : '0;
					res_d.item_valid = pend_vld_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			cnt_q      <= '{default: '0};
			idx_q      <= '0;
			phase_q    <= 1'b0;
			pend_vld_q <= 1'b0;
			ans_q      <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= res_load;
			if (ctl.load) begin
				idx_q      <= '0;
				phase_q    <= 1'b0;
				pend_vld_q <= 1'b0;
				ans_q      <= 1'b1;
			end
			if (add_en) begin
				vld_q[sel_q][free_idx] <= 1'b1;
				cnt_q[sel_q]           <= cnt_q[sel_q] + 1'b1;
			end
			if (rem_en) begin
				vld_q[sel_q][hit_idx] <= 1'b0;
				cnt_q[sel_q]          <= cnt_q[sel_q] - 1'b1;
			end
			if (ctl.scan) begin
				if (idx_q == LastIdx) begin
					idx_q   <= '0;
					phase_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
				if (take) begin
					pend_vld_q <= 1'b1;
				end
				if (fail) begin
					ans_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= request.cmd;
			sel_q <= request.which_set;
			key_q <= request.value;
		end
		if (add_en) begin
			val_q[sel_q][free_idx] <= key_q;
		end
		if (ctl.scan && take) begin
			pend_item_q <= cur_val;
		end
		if (res_load) begin
			out_q <= res_d;
		end
	end

	assign result = out_q;
	assign strobe = strobe_q;

endmodule

`default_nettype wire

@@ src/two_set_membership_engine.sv @@
// Top level of the two-set membership engine: joins tsme_ctrl and tsme_datapath.
// Uses tsme_pkg and two_set_membership_engine_macros.svh.
//
// An item is taken when start is high and busy is low. Every result is shown for
// one cycle with strobe high and cannot be held off; the receiver must take it.
// Add, remove, contains and size pass a load and an execute step, the result
// appearing the cycle after the execute step while the next item may already be
// taken. Subset, equal and intersection scan the slots of the selected set and
// union those of both sets: the scan visits one slot per cycle and checks it
// against the other set through the shared compare bank. Union and intersection
// hold each member until the scan finds the next one and show it the cycle after
// that slot; the final result, with last, is loaded from the finish step.
`timescale 1ns / 1ps
`default_nettype none
`include "two_set_membership_engine_macros.svh"

module two_set_membership_engine import tsme_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire      clk,
	input  wire      arst_n,
	input  wire      start,
	input  request_t request,
	output logic     busy,
	output result_t  result,
	output logic     strobe
);

	ctrl_cmd_t  ctl;
	dp_status_t stat;

	tsme_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (request.cmd),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	tsme_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.stat    (stat),
		.result  (result),
		.strobe  (strobe)
	);

	`TSME_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`TSME_ASSERT_IMP(a_short_result, clk, arst_n,
		$past(arst_n && start && !busy && (request.cmd == OP_ADD ||
			request.cmd == OP_REMOVE || request.cmd == OP_CONTAINS ||
			request.cmd == OP_SIZE), 2),
		strobe && result.last)
	`TSME_ASSERT_IMP(a_last_when_idle, clk, arst_n, strobe, result.last == !busy)
	`TSME_ASSERT_IMP(a_marker_final, clk, arst_n, strobe && !result.item_valid, result.last)

endmodule

`default_nettype wire
